>>> design/two_level_page_table_walker_assert.svh
// assertion macros for the page table walker checker
// no dependencies; included by the checker file
`ifndef TWO_LEVEL_PAGE_TABLE_WALKER_ASSERT_SVH
`define TWO_LEVEL_PAGE_TABLE_WALKER_ASSERT_SVH

// checked outside reset
`define TLPTW_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked in every cycle, reset included
`define TLPTW_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> design/tlptw_pkg.sv
// shared constants and types for the two-level page table walker
// no dependencies
`timescale 1ns / 1ps

package tlptw_pkg;

  localparam int unsigned MEM_WORDS = 65536;
  localparam int unsigned MAX_RUN   = 1024;
  localparam int unsigned MEM_AW    = $clog2(MEM_WORDS);
  localparam int unsigned CNT_W     = 11;

  // longest run that an 11-bit page count can ask for after saturation
  localparam logic [CNT_W-1:0] RUN_CLIP =
    CNT_W'((MAX_RUN > ((1 << CNT_W) - 1)) ? ((1 << CNT_W) - 1) : MAX_RUN);

  localparam logic [1:0] OP_TRANSLATE = 2'd0;
  localparam logic [1:0] OP_MAP       = 2'd1;
  localparam logic [1:0] OP_WRITE     = 2'd2;

  typedef struct packed {
    logic [31:0] addr;
    logic        present;
  } result_t;

endpackage

>>> design/tlptw_in_if.sv
// request channel of the page table walker
// no dependencies
`timescale 1ns / 1ps

interface tlptw_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [31:0] virt_addr;
  logic [31:0] phys_addr;
  logic [11:0] entry_flags;
  logic [10:0] page_count;
  logic [15:0] word_address;
  logic [31:0] word_data;

  modport source (output valid, opcode, virt_addr, phys_addr, entry_flags, page_count,
                  word_address, word_data, input ready);
  modport sink (input valid, opcode, virt_addr, phys_addr, entry_flags, page_count,
                word_address, word_data, output ready);
endinterface

>>> design/tlptw_out_if.sv
// result channel of the page table walker
// no dependencies
`timescale 1ns / 1ps

interface tlptw_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] translated_addr;
  logic        present;

  modport source (output valid, translated_addr, present, input ready);
  modport sink (input valid, translated_addr, present, output ready);
endinterface

>>> design/two_level_page_table_walker.sv
// two-level page table walker: translate, map page runs, load store words
// depends on tlptw_pkg, tlptw_in_if, tlptw_out_if and tlptw_ram
`timescale 1ns / 1ps
//
// usage
//   in_ch takes one request at a time (valid/ready): opcode 0 walks the
//   directory and table for virt_addr, opcode 1 maps page_count pages, at
//   most 1024, starting at virt_addr/phys_addr, opcode 2 writes word_data to the
//   store word word_address. every request gives one result on out_ch;
//   only a translate gives a nonzero address and a present flag.
//   cfg_wr_en/cfg_wr_data load the directory base; write it only while idle.
// steps
//   one store read port paces everything. translate with both entries
//   present: directory read, table read, then the result; an absent
//   directory entry skips the table read, a zero base skips both reads.
//   map: per page a directory read and a table entry write, then the
//   result. empty map run, write word and unused opcodes go straight to
//   the result.
// reset
//   after rst_n the store is zeroed one word a cycle: in_ch.ready stays low
//   until all 65536 words are clear. the result sits in an output register, so
//   a stalled receiver does not block the next request, only the one after it.

module two_level_page_table_walker (
  input  logic        clk,
  input  logic        rst_n,
  tlptw_in_if.sink    in_ch,
  tlptw_out_if.source out_ch,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data
);

  import tlptw_pkg::*;

  localparam logic [2:0] ST_CLEAR  = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_PDE    = 3'd2;
  localparam logic [2:0] ST_PTE    = 3'd3;
  localparam logic [2:0] ST_MAP_RD = 3'd4;
  localparam logic [2:0] ST_MAP_WR = 3'd5;
  localparam logic [2:0] ST_RESULT = 3'd6;

  localparam logic [MEM_AW-1:0] CLR_LAST = MEM_AW'(MEM_WORDS - 1);

  logic [2:0]        state_r, state_nxt;
  logic [MEM_AW-1:0] clr_idx_r, clr_idx_nxt;
  logic [31:0]       base_r;
  logic [31:0]       va_r, va_nxt;
  logic [31:0]       pa_r, pa_nxt;
  logic [11:0]       flags_r, flags_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  result_t           res_r, res_nxt;
  logic              out_valid_r, out_valid_nxt;
  result_t           out_res_r, out_res_nxt;

  logic              ram_we;
  logic [MEM_AW-1:0] ram_waddr;
  logic [31:0]       ram_wdata;
  logic [MEM_AW-1:0] ram_raddr;
  logic [31:0]       ram_rdata;

  logic [31:0]       va_sel;
  logic [31:0]       dir_byte;
  logic [MEM_AW-1:0] dir_word;
  logic [29:0]       tab_full;
  logic [MEM_AW-1:0] tab_word;
  logic [31:0]       wa_ext;
  logic [CNT_W-1:0]  cnt_in;

  tlptw_ram #(
    .WIDTH (32),
    .DEPTH (MEM_WORDS)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  // directory slot of the current address, table slot from the entry just read
  assign va_sel   = (state_r == ST_IDLE) ? in_ch.virt_addr : va_r;
  assign dir_byte = base_r + {20'b0, va_sel[31:22], 2'b00};
  assign dir_word = dir_byte[MEM_AW+1:2];
  assign tab_full = {ram_rdata[31:12], va_r[21:12]};
  assign tab_word = tab_full[MEM_AW-1:0];
  assign wa_ext   = {16'b0, in_ch.word_address};
  assign cnt_in   = (in_ch.page_count > RUN_CLIP) ? RUN_CLIP : in_ch.page_count;

  always_comb begin
    state_nxt     = state_r;
    clr_idx_nxt   = clr_idx_r;
    va_nxt        = va_r;
    pa_nxt        = pa_r;
    flags_nxt     = flags_r;
    cnt_nxt       = cnt_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;
    ram_we        = 1'b0;
    ram_waddr     = '0;
    ram_wdata     = '0;
    ram_raddr     = dir_word;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_CLEAR: begin
        ram_we      = 1'b1;
        ram_waddr   = clr_idx_r;
        clr_idx_nxt = clr_idx_r + MEM_AW'(1);
        if (clr_idx_r == CLR_LAST) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_ch.valid) begin
          va_nxt    = in_ch.virt_addr;
          pa_nxt    = in_ch.phys_addr;
          flags_nxt = in_ch.entry_flags;
          cnt_nxt   = cnt_in;
          res_nxt   = '0;
          unique case (in_ch.opcode)
            OP_TRANSLATE: begin
              state_nxt = (base_r == 32'd0) ? ST_RESULT : ST_PDE;
            end
            OP_MAP: begin
              state_nxt = (cnt_in == '0) ? ST_RESULT : ST_MAP_WR;
            end
            OP_WRITE: begin
              ram_we    = 1'b1;
              ram_waddr = wa_ext[MEM_AW-1:0];
              ram_wdata = in_ch.word_data;
              state_nxt = ST_RESULT;
            end
            default: begin
              state_nxt = ST_RESULT;
            end
          endcase
        end
      end
      ST_PDE: begin
        if (ram_rdata[0]) begin
          ram_raddr = tab_word;
          state_nxt = ST_PTE;
        end else begin
          state_nxt = ST_RESULT;
        end
      end
      ST_PTE: begin
        if (ram_rdata[0]) begin
          res_nxt.addr    = {ram_rdata[31:12], va_r[11:0]};
          res_nxt.present = 1'b1;
        end
        state_nxt = ST_RESULT;
      end
      ST_MAP_WR: begin
        // directory entry is used as read, present or not
        ram_we    = 1'b1;
        ram_waddr = tab_word;
        ram_wdata = pa_r | {20'b0, flags_r} | 32'd1;
        va_nxt    = va_r + 32'd4096;
        pa_nxt    = pa_r + 32'd4096;
        cnt_nxt   = cnt_r - CNT_W'(1);
        state_nxt = (cnt_r == CNT_W'(1)) ? ST_RESULT : ST_MAP_RD;
      end
      ST_MAP_RD: begin
        state_nxt = ST_MAP_WR;
      end
      ST_RESULT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_res_nxt   = res_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_idx_r   <= '0;
      out_valid_r <= 1'b0;
      base_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      clr_idx_r   <= clr_idx_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        base_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    va_r      <= va_nxt;
    pa_r      <= pa_nxt;
    flags_r   <= flags_nxt;
    cnt_r     <= cnt_nxt;
    res_r     <= res_nxt;
    out_res_r <= out_res_nxt;
  end

  assign in_ch.ready            = (state_r == ST_IDLE);
  assign out_ch.valid           = out_valid_r;
  assign out_ch.translated_addr = out_res_r.addr;
  assign out_ch.present         = out_res_r.present;

endmodule

>>> design/tlptw_ram.sv
// generic single-clock ram, one write port and one registered read port
// no dependencies
`timescale 1ns / 1ps

module tlptw_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

>>> design/tlptw_checker.sv
// port-level checks for the page table walker, bound to the top level
// depends on two_level_page_table_walker_assert.svh and the top level
`timescale 1ns / 1ps
`include "two_level_page_table_walker_assert.svh"

module tlptw_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_translated_addr,
  input logic        out_present
);

  // a result waits unchanged until taken
  `TLPTW_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_translated_addr) && $stable(out_present), "result dropped or changed while stalled")

  // store clearing keeps requests out right after reset
  `TLPTW_ASSERT_ALWAYS(a_clear_after_reset, clk, !rst_n |=> !in_ready, "request taken during store clear")

  // one request at a time
  `TLPTW_ASSERT(a_one_at_a_time, clk, rst_n, in_valid && in_ready |=> !in_ready, "ready still high after a request")

  // a new result only appears while the walker is busy
  `TLPTW_ASSERT(a_result_from_busy, clk, rst_n, $rose(out_valid) |-> !$past(in_ready), "result appeared while idle")

endmodule

bind two_level_page_table_walker tlptw_checker u_tlptw_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .in_valid            (in_ch.valid),
  .in_ready            (in_ch.ready),
  .out_valid           (out_ch.valid),
  .out_ready           (out_ch.ready),
  .out_translated_addr (out_ch.translated_addr),
  .out_present         (out_ch.present)
);
